>>> hdl/dnsarp_pkg.sv
// dnsarp_pkg: constants, result types and shared codes for the dns answer parser
// no dependencies; imported by dnsarp_res_if and by every module of the block
package dnsarp_pkg;

	localparam int MAX_MESSAGE_DEF = 2048;
	localparam int MAX_RECORDS_DEF = 16;

	// result buffer between the parser and the output channel
	localparam int RES_DEPTH = 4;

	localparam logic [15:0] EXPECTED_ID_RST = 16'h4c37;

	localparam int ADDR_W    = 64;
	localparam int RES_CNT_W = 5;

	// header byte positions
	localparam int POS_ID_HI = 0;
	localparam int POS_ID_LO = 1;
	localparam int POS_FLAGS = 2;
	localparam int POS_QD_HI = 4;
	localparam int POS_QD_LO = 5;
	localparam int POS_AN_HI = 6;
	localparam int POS_AN_LO = 7;
	localparam int POS_HDR_END = 11;

	// answer fixed part positions
	localparam logic [3:0] FPOS_TYPE_HI = 4'd0;
	localparam logic [3:0] FPOS_TYPE_LO = 4'd1;
	localparam logic [3:0] FPOS_LEN_HI  = 4'd8;
	localparam logic [3:0] FPOS_LEN_LO  = 4'd9;

	localparam logic [3:0] QFIXED_LEN = 4'd4;
	localparam logic [3:0] AFIXED_LEN = 4'd10;

	localparam logic [7:0] PTR_MARK = 8'hc0;

	localparam logic [15:0] TYPE_A    = 16'd1;
	localparam logic [15:0] TYPE_AAAA = 16'd28;
	localparam logic [15:0] LEN_A     = 16'd4;
	localparam logic [15:0] LEN_AAAA  = 16'd16;

	localparam logic KIND_A    = 1'b0;
	localparam logic KIND_AAAA = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_HDR   = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic                 is_done;
		logic                 record_kind;
		logic [ADDR_W-1:0]    addr_high;
		logic [ADDR_W-1:0]    addr_low;
		logic [RES_CNT_W-1:0] v4_count;
		logic [RES_CNT_W-1:0] v6_count;
		logic [1:0]           status;
		logic                 last_of_run;
	} result_t;

	// up to two results per byte: a record first, then the done summary
	typedef struct packed {
		logic    rec_v;
		logic    done_v;
		result_t rec;
		result_t done;
	} push_t;

endpackage

>>> hdl/dnsarp_ifs.sv
// dnsarp_ifs: valid/ready channels for message bytes and parse results
// depends on dnsarp_pkg for field widths
interface dnsarp_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source(output valid, output data_byte, output is_last, input ready);
	modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

interface dnsarp_res_if;
	import dnsarp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 is_done;
	logic                 record_kind;
	logic [ADDR_W-1:0]    addr_high;
	logic [ADDR_W-1:0]    addr_low;
	logic [RES_CNT_W-1:0] v4_count;
	logic [RES_CNT_W-1:0] v6_count;
	logic [1:0]           status;
	logic                 last_of_run;

	modport source(output valid, output is_done, output record_kind, output addr_high,
		output addr_low, output v4_count, output v6_count, output status,
		output last_of_run, input ready);
	modport sink(input valid, input is_done, input record_kind, input addr_high,
		input addr_low, input v4_count, input v6_count, input status,
		input last_of_run, output ready);
endinterface

>>> hdl/dnsarp_parse.sv
// dnsarp_parse: per-byte dns reply parser state and result generation
// depends on dnsarp_pkg and dnsarp_msg_if
module dnsarp_parse #(
	parameter int MAX_MESSAGE = dnsarp_pkg::MAX_MESSAGE_DEF,
	parameter int MAX_RECORDS = dnsarp_pkg::MAX_RECORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         expected_id,
	input  logic                room,
	dnsarp_msg_if.sink          msg,
	output dnsarp_pkg::push_t   push
);
	import dnsarp_pkg::*;

	localparam int OFS_W = $clog2(MAX_MESSAGE + 1);
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	typedef enum logic [7:0] {
		PH_HEADER = 8'b0000_0001,
		PH_QNAME  = 8'b0000_0010,
		PH_QFIXED = 8'b0000_0100,
		PH_ANAME  = 8'b0000_1000,
		PH_AFIXED = 8'b0001_0000,
		PH_RDATA  = 8'b0010_0000,
		PH_DONE   = 8'b0100_0000,
		PH_REJECT = 8'b1000_0000
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [OFS_W-1:0]  offset_q, offset_n;
	logic [15:0]       qleft_q, qleft_n;
	logic [15:0]       aleft_q, aleft_n;
	logic [7:0]        lbl_q, lbl_n;
	logic [3:0]        fix_q, fix_n;
	logic [15:0]       rtype_q, rtype_n;
	logic [15:0]       rlen_q, rlen_n;
	logic [ADDR_W-1:0] acc_hi_q, acc_hi_n;
	logic [ADDR_W-1:0] acc_lo_q, acc_lo_n;
	logic [CNT_W-1:0]  cnt4_q, cnt4_n;
	logic [CNT_W-1:0]  cnt6_q, cnt6_n;
	logic [3:0]        fpos;
	logic [7:0]        b;
	logic              acc;

	assign msg.ready = room;
	assign acc       = msg.valid && room;
	assign b         = msg.data_byte;
	assign fpos      = AFIXED_LEN - fix_q;

	always_comb begin
		phase_n  = phase_q;
		offset_n = offset_q;
		qleft_n  = qleft_q;
		aleft_n  = aleft_q;
		lbl_n    = lbl_q;
		fix_n    = fix_q;
		rtype_n  = rtype_q;
		rlen_n   = rlen_q;
		acc_hi_n = acc_hi_q;
		acc_lo_n = acc_lo_q;
		cnt4_n   = cnt4_q;
		cnt6_n   = cnt6_q;
		push     = '0;
		if (acc) begin
			if (offset_q < OFS_W'(MAX_MESSAGE)) begin
				offset_n = offset_q + OFS_W'(1);
				unique case (phase_q)
					PH_HEADER: begin
						if ((offset_q == OFS_W'(POS_ID_HI) && b != expected_id[15:8]) ||
							(offset_q == OFS_W'(POS_ID_LO) && b != expected_id[7:0]) ||
							(offset_q == OFS_W'(POS_FLAGS) && !b[7])) begin
							phase_n = PH_REJECT;
						end else begin
							if (offset_q == OFS_W'(POS_QD_HI)) qleft_n[15:8] = b;
							if (offset_q == OFS_W'(POS_QD_LO)) qleft_n[7:0] = b;
							if (offset_q == OFS_W'(POS_AN_HI)) aleft_n[15:8] = b;
							if (offset_q == OFS_W'(POS_AN_LO)) aleft_n[7:0] = b;
							if (offset_q == OFS_W'(POS_HDR_END)) begin
								lbl_n = '0;
								if (qleft_q != '0) phase_n = PH_QNAME;
								else phase_n = (aleft_q != '0) ? PH_ANAME : PH_DONE;
							end
						end
					end
					PH_QNAME: begin
						if (lbl_q != '0) begin
							lbl_n = lbl_q - 8'd1;
						end else if (b == '0) begin
							fix_n   = QFIXED_LEN;
							phase_n = PH_QFIXED;
						end else if ((b & PTR_MARK) == PTR_MARK) begin
							// second pointer byte rides along as an extra fixed byte
							fix_n   = QFIXED_LEN + 4'd1;
							phase_n = PH_QFIXED;
						end else begin
							lbl_n = b;
						end
					end
					PH_QFIXED: begin
						fix_n = fix_q - 4'd1;
						if (fix_n == '0) begin
							qleft_n = qleft_q - 16'd1;
							lbl_n   = '0;
							if (qleft_n != '0) phase_n = PH_QNAME;
							else phase_n = (aleft_q != '0) ? PH_ANAME : PH_DONE;
						end
					end
					PH_ANAME: begin
						if (lbl_q != '0) begin
							lbl_n = lbl_q - 8'd1;
						end else if (b == '0) begin
							fix_n   = AFIXED_LEN;
							phase_n = PH_AFIXED;
						end else if ((b & PTR_MARK) == PTR_MARK) begin
							fix_n   = AFIXED_LEN + 4'd1;
							phase_n = PH_AFIXED;
						end else begin
							lbl_n = b;
						end
					end
					PH_AFIXED: begin
						if (fix_q <= AFIXED_LEN) begin
							if (fpos == FPOS_TYPE_HI) rtype_n[15:8] = b;
							if (fpos == FPOS_TYPE_LO) rtype_n[7:0] = b;
							if (fpos == FPOS_LEN_HI) rlen_n[15:8] = b;
							if (fpos == FPOS_LEN_LO) rlen_n[7:0] = b;
						end
						fix_n = fix_q - 4'd1;
						if (fix_n == '0) begin
							// only well-formed a / aaaa records keep their type
							if (!((rtype_n == TYPE_A && rlen_n == LEN_A) ||
								(rtype_n == TYPE_AAAA && rlen_n == LEN_AAAA))) begin
								rtype_n = '0;
							end
							acc_hi_n = '0;
							acc_lo_n = '0;
							lbl_n    = '0;
							if (rlen_n != '0) begin
								phase_n = PH_RDATA;
							end else begin
								aleft_n = aleft_q - 16'd1;
								phase_n = (aleft_n != '0) ? PH_ANAME : PH_DONE;
							end
						end
					end
					PH_RDATA: begin
						acc_hi_n = {acc_hi_q[ADDR_W-9:0], acc_lo_q[ADDR_W-1:ADDR_W-8]};
						acc_lo_n = {acc_lo_q[ADDR_W-9:0], b};
						rlen_n   = rlen_q - 16'd1;
						if (rlen_n == '0) begin
							if (rtype_q == TYPE_A && cnt4_q < CNT_W'(MAX_RECORDS)) begin
								push.rec_v            = 1'b1;
								push.rec.record_kind  = KIND_A;
								push.rec.addr_low     = {32'd0, acc_lo_n[31:0]};
								cnt4_n                = cnt4_q + CNT_W'(1);
							end else if (rtype_q == TYPE_AAAA &&
								cnt6_q < CNT_W'(MAX_RECORDS)) begin
								push.rec_v            = 1'b1;
								push.rec.record_kind  = KIND_AAAA;
								push.rec.addr_high    = acc_hi_n;
								push.rec.addr_low     = acc_lo_n;
								cnt6_n                = cnt6_q + CNT_W'(1);
							end
							push.rec.last_of_run = !msg.is_last;
							aleft_n = aleft_q - 16'd1;
							phase_n = (aleft_n != '0) ? PH_ANAME : PH_DONE;
						end
					end
					PH_DONE, PH_REJECT: begin
					end
					default: begin
					end
				endcase
			end
			if (msg.is_last) begin
				push.done_v           = 1'b1;
				push.done.is_done     = 1'b1;
				push.done.v4_count    = RES_CNT_W'(cnt4_n);
				push.done.v6_count    = RES_CNT_W'(cnt6_n);
				push.done.last_of_run = 1'b1;
				if (phase_n == PH_HEADER || phase_n == PH_REJECT) push.done.status = ST_HDR;
				else if (phase_n == PH_DONE) push.done.status = ST_OK;
				else push.done.status = ST_TRUNC;
				// start afresh for the next message
				phase_n  = PH_HEADER;
				offset_n = '0;
				qleft_n  = '0;
				aleft_n  = '0;
				lbl_n    = '0;
				fix_n    = '0;
				rtype_n  = '0;
				rlen_n   = '0;
				acc_hi_n = '0;
				acc_lo_n = '0;
				cnt4_n   = '0;
				cnt6_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			offset_q <= '0;
			qleft_q  <= '0;
			aleft_q  <= '0;
			lbl_q    <= '0;
			fix_q    <= '0;
			rtype_q  <= '0;
			rlen_q   <= '0;
			acc_hi_q <= '0;
			acc_lo_q <= '0;
			cnt4_q   <= '0;
			cnt6_q   <= '0;
		end else begin
			phase_q  <= phase_n;
			offset_q <= offset_n;
			qleft_q  <= qleft_n;
			aleft_q  <= aleft_n;
			lbl_q    <= lbl_n;
			fix_q    <= fix_n;
			rtype_q  <= rtype_n;
			rlen_q   <= rlen_n;
			acc_hi_q <= acc_hi_n;
			acc_lo_q <= acc_lo_n;
			cnt4_q   <= cnt4_n;
			cnt6_q   <= cnt6_n;
		end
	end

endmodule

>>> hdl/dnsarp_fifo.sv
// dnsarp_fifo: small result buffer taking up to two results a cycle
// depends on dnsarp_pkg and dnsarp_res_if
module dnsarp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  dnsarp_pkg::push_t push,
	output logic              room,
	dnsarp_res_if.source      res
);
	import dnsarp_pkg::*;

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	result_t          mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q, wp_done;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_push;
	logic             pop;
	result_t          head;

	assign head    = mem_q[rp_q];
	assign pop     = res.valid && res.ready;
	assign n_push  = CNT_W'(push.rec_v) + CNT_W'(push.done_v);
	assign wp_done = wp_q + PTR_W'(push.rec_v);
	// two free entries so a record and a done summary always fit
	assign room    = cnt_q <= CNT_W'(RES_DEPTH - 2);

	assign res.valid       = cnt_q != '0;
	assign res.is_done     = head.is_done;
	assign res.record_kind = head.record_kind;
	assign res.addr_high   = head.addr_high;
	assign res.addr_low    = head.addr_low;
	assign res.v4_count    = head.v4_count;
	assign res.v6_count    = head.v6_count;
	assign res.status      = head.status;
	assign res.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.rec_v) mem_q[wp_q] <= push.rec;
		if (push.done_v) mem_q[wp_done] <= push.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(n_push);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/dns_answer_record_parser_unit.sv
// dns_answer_record_parser_unit: top level of the dns reply a/aaaa address extractor
// depends on dnsarp_pkg, dnsarp_ifs, dnsarp_parse and dnsarp_fifo
//
// Takes a dns reply one byte per transfer on msg and returns address records and an
// end-of-message summary on res. Each byte updates the parser state in the cycle it is
// accepted; any record or summary it completes sits in a four-entry result buffer from
// the next cycle on. A byte can be accepted every cycle; msg.ready drops only while the
// result buffer has fewer than two free entries, which happens when res is held off.
// The reply id is compared against a register written through cfg_we / cfg_wdata,
// reset to 0x4c37; the user must write it only while idle, the block does not check.
module dns_answer_record_parser_unit #(
	parameter int MAX_MESSAGE = dnsarp_pkg::MAX_MESSAGE_DEF,
	parameter int MAX_RECORDS = dnsarp_pkg::MAX_RECORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	dnsarp_msg_if.sink   msg,
	dnsarp_res_if.source res
);
	import dnsarp_pkg::*;

	logic [15:0] expected_id_q;
	logic        room;
	push_t       push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= EXPECTED_ID_RST;
		end else if (cfg_we) begin
			expected_id_q <= cfg_wdata;
		end
	end

	dnsarp_parse #(
		.MAX_MESSAGE(MAX_MESSAGE),
		.MAX_RECORDS(MAX_RECORDS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.expected_id(expected_id_q),
		.room       (room),
		.msg        (msg),
		.push       (push)
	);

	dnsarp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.res   (res)
	);

	// the final byte always leaves a summary waiting
	a_last_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && msg.is_last |=> res.valid)
		else $error("no result after final byte");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_done |-> res.last_of_run)
		else $error("summary not last of run");

	a_record_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.is_done |->
			(res.v4_count == '0 && res.v6_count == '0 && res.status == ST_OK))
		else $error("record carries summary fields");

	a_v4_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.is_done && res.record_kind == KIND_A |->
			(res.addr_high == '0 && res.addr_low[63:32] == '0))
		else $error("a record with upper address bits set");

endmodule

>>> bench/dns_answer_record_parser_unit_test.sv
`timescale 1ns / 100ps
// self-checking bench for dns_answer_record_parser_unit: byte stream in, address records out
// depends on dnsarp_pkg, dnsarp_ifs and the rtl of the parser unit
module dns_answer_record_parser_unit_test;
	import dnsarp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 350;

	typedef enum logic [2:0] {
		P_HEADER, P_QNAME, P_QFIXED, P_ANAME, P_AFIXED, P_RDATA, P_DONE, P_REJECT
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       typed;
		result_t    want;
	} stim_row_t;

	localparam result_t NO_RES     = '0;
	localparam result_t DONE_HDR   = '{1'b1, KIND_A, 64'd0, 64'd0, 5'd0, 5'd0, ST_HDR, 1'b1};
	localparam result_t DONE_TRUNC = '{1'b1, KIND_A, 64'd0, 64'd0, 5'd0, 5'd0, ST_TRUNC, 1'b1};
	localparam result_t DONE_OK    = '{1'b1, KIND_A, 64'd0, 64'd0, 5'd0, 5'd0, ST_OK, 1'b1};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	dnsarp_msg_if msg_ch();
	dnsarp_res_if res_ch();

	dns_answer_record_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.msg      (msg_ch),
		.res      (res_ch)
	);

	// rejected id, header announcing one answer then cut, then an empty clean reply
	stim_row_t directed_rows [25] = '{
		'{8'hff, 1'b1, 1'b1, DONE_HDR},
		'{EXPECTED_ID_RST[15:8], 1'b0, 1'b0, NO_RES},
		'{EXPECTED_ID_RST[7:0], 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b1, DONE_TRUNC},
		'{EXPECTED_ID_RST[15:8], 1'b0, 1'b0, NO_RES},
		'{EXPECTED_ID_RST[7:0], 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, DONE_OK}
	};

	result_t      pending_results[$];
	logic [7:0]   reply_bytes[$];
	int           mismatches;
	int           results_seen;
	int           stall_cycles;
	bit           send_burst;
	bit           recv_burst;

	// parser copy
	logic [15:0]  reply_id_reg;
	int           offset;
	parse_phase_t parse_ph;
	logic [15:0]  qd_left;
	logic [15:0]  an_left;
	logic [7:0]   label_left;
	logic [3:0]   fixed_left;
	logic [15:0]  rec_type;
	logic [15:0]  rd_left;
	logic [63:0]  acc_hi;
	logic [63:0]  acc_lo;
	int           n_a;
	int           n_aaaa;

	task automatic clear_message();
		offset     = 0;
		parse_ph   = P_HEADER;
		qd_left    = '0;
		an_left    = '0;
		label_left = '0;
		fixed_left = '0;
		rec_type   = '0;
		rd_left    = '0;
		acc_hi     = '0;
		acc_lo     = '0;
		n_a        = 0;
		n_aaaa     = 0;
	endtask

	task automatic next_section();
		label_left = '0;
		if (qd_left != 0)
			parse_ph = P_QNAME;
		else
			parse_ph = (an_left != 0) ? P_ANAME : P_DONE;
	endtask

	task automatic answer_done();
		an_left  = an_left - 16'd1;
		parse_ph = (an_left != 0) ? P_ANAME : P_DONE;
	endtask

	task automatic name_byte(input logic [7:0] c, input logic [3:0] flen,
		input parse_phase_t nxt);
		if (label_left != 0) begin
			label_left = label_left - 8'd1;
		end else if (c == 8'h00) begin
			fixed_left = flen;
			parse_ph   = nxt;
		end else if ((c & PTR_MARK) == PTR_MARK) begin
			// second pointer byte rides along as an extra fixed byte
			fixed_left = flen + 4'd1;
			parse_ph   = nxt;
		end else begin
			label_left = c;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic l, input bit keep);
		result_t    outs[2];
		int         n;
		int         i;
		logic [3:0] fpos;
		logic [1:0] st;
		n       = 0;
		outs[0] = '0;
		outs[1] = '0;
		if (offset < MAX_MESSAGE_DEF) begin
			case (parse_ph)
			P_HEADER: begin
				if ((offset == POS_ID_HI && b != reply_id_reg[15:8]) ||
					(offset == POS_ID_LO && b != reply_id_reg[7:0]) ||
					(offset == POS_FLAGS && !b[7])) begin
					parse_ph = P_REJECT;
				end else begin
					if (offset == POS_QD_HI) qd_left[15:8] = b;
					if (offset == POS_QD_LO) qd_left[7:0] = b;
					if (offset == POS_AN_HI) an_left[15:8] = b;
					if (offset == POS_AN_LO) an_left[7:0] = b;
					if (offset == POS_HDR_END) next_section();
				end
			end
			P_QNAME: name_byte(b, QFIXED_LEN, P_QFIXED);
			P_QFIXED: begin
				fixed_left = fixed_left - 4'd1;
				if (fixed_left == 0) begin
					qd_left = qd_left - 16'd1;
					next_section();
				end
			end
			P_ANAME: name_byte(b, AFIXED_LEN, P_AFIXED);
			P_AFIXED: begin
				if (fixed_left <= AFIXED_LEN) begin
					fpos = AFIXED_LEN - fixed_left;
					case (fpos)
					FPOS_TYPE_HI: rec_type[15:8] = b;
					FPOS_TYPE_LO: rec_type[7:0] = b;
					FPOS_LEN_HI:  rd_left[15:8] = b;
					FPOS_LEN_LO:  rd_left[7:0] = b;
					default: ;
					endcase
				end
				fixed_left = fixed_left - 4'd1;
				if (fixed_left == 0) begin
					if (!((rec_type == TYPE_A && rd_left == LEN_A) ||
						(rec_type == TYPE_AAAA && rd_left == LEN_AAAA)))
						rec_type = '0;
					acc_hi     = '0;
					acc_lo     = '0;
					label_left = '0;
					if (rd_left != 0)
						parse_ph = P_RDATA;
					else
						answer_done();
				end
			end
			P_RDATA: begin
				acc_hi  = {acc_hi[55:0], acc_lo[63:56]};
				acc_lo  = {acc_lo[55:0], b};
				rd_left = rd_left - 16'd1;
				if (rd_left == 0) begin
					if (rec_type == TYPE_A && n_a < MAX_RECORDS_DEF) begin
						outs[0].record_kind = KIND_A;
						outs[0].addr_low    = {32'd0, acc_lo[31:0]};
						n_a++;
						n = 1;
					end else if (rec_type == TYPE_AAAA && n_aaaa < MAX_RECORDS_DEF) begin
						outs[0].record_kind = KIND_AAAA;
						outs[0].addr_high   = acc_hi;
						outs[0].addr_low    = acc_lo;
						n_aaaa++;
						n = 1;
					end
					answer_done();
				end
			end
			default: ;
			endcase
			offset++;
		end
		if (l) begin
			if (parse_ph == P_HEADER || parse_ph == P_REJECT)
				st = ST_HDR;
			else if (parse_ph == P_DONE)
				st = ST_OK;
			else
				st = ST_TRUNC;
			outs[n].is_done  = 1'b1;
			outs[n].v4_count = n_a[4:0];
			outs[n].v6_count = n_aaaa[4:0];
			outs[n].status   = st;
			n++;
			clear_message();
		end
		if (n > 0) outs[n-1].last_of_run = 1'b1;
		if (keep)
			for (i = 0; i < n; i++) pending_results.push_back(outs[i]);
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// one transfer on the byte channel, with a random lead-in gap
	task automatic put_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.is_last   <= l;
		do @(posedge clk); while (!msg_ch.ready);
	endtask

	task automatic drain(input int settle);
		msg_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_id(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		reply_id_reg = v;
	endtask

	task automatic push_random(input int n);
		repeat (n) reply_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic push_name(input bit ptr_only);
		int labels;
		int len;
		if (!ptr_only) begin
			labels = $urandom_range(0, 3);
			repeat (labels) begin
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(0, 1) ? $urandom_range(64, 70) : $urandom_range(128, 134);
				else
					len = $urandom_range(1, 8);
				reply_bytes.push_back(8'(len));
				push_random(len);
			end
		end
		if (ptr_only || $urandom_range(0, 1) == 1) begin
			reply_bytes.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
			push_random(1);
		end else begin
			reply_bytes.push_back(8'h00);
		end
	endtask

	// crowded replies alternate a and aaaa with clean headers and pointer names
	task automatic build_reply(input int n_an, input bit crowd);
		int          n_q;
		int          k;
		int          kind;
		int          cut;
		logic [15:0] id;
		logic [15:0] an_field;
		logic [15:0] rt;
		logic [15:0] rl;
		logic [7:0]  flags;
		reply_bytes.delete();
		if (!crowd && $urandom_range(0, 9) == 0) begin
			push_random($urandom_range(1, 20));
			return;
		end
		id = reply_id_reg;
		if (!crowd && $urandom_range(0, 15) == 0)
			id = reply_id_reg ^ 16'($urandom_range(1, 65535));
		flags    = 8'($urandom_range(0, 255));
		flags[7] = crowd || ($urandom_range(0, 15) != 0);
		n_q      = crowd ? 0 : $urandom_range(0, 2);
		an_field = 16'(n_an);
		if (!crowd && $urandom_range(0, 9) == 0) an_field = 16'($urandom_range(0, n_an + 2));
		reply_bytes.push_back(id[15:8]);
		reply_bytes.push_back(id[7:0]);
		reply_bytes.push_back(flags);
		push_random(1);
		reply_bytes.push_back(8'd0);
		reply_bytes.push_back(8'(n_q));
		reply_bytes.push_back(an_field[15:8]);
		reply_bytes.push_back(an_field[7:0]);
		push_random(4);
		repeat (n_q) begin
			push_name(1'b0);
			push_random(4);
		end
		for (k = 0; k < n_an; k++) begin
			push_name(crowd);
			kind = crowd ? 1 + (k % 2) : $urandom_range(0, 3);
			case (kind)
			0, 1: begin
				rt = TYPE_A;
				rl = LEN_A;
			end
			2: begin
				rt = TYPE_AAAA;
				rl = LEN_AAAA;
			end
			default: begin
				rt = 16'($urandom_range(0, 65535));
				rl = 16'($urandom_range(0, 6));
			end
			endcase
			if (!crowd && $urandom_range(0, 7) == 0) rl = 16'($urandom_range(0, 20));
			reply_bytes.push_back(rt[15:8]);
			reply_bytes.push_back(rt[7:0]);
			push_random(6);
			reply_bytes.push_back(rl[15:8]);
			reply_bytes.push_back(rl[7:0]);
			push_random(rl);
		end
		if (!crowd && $urandom_range(0, 4) == 0) push_random($urandom_range(1, 5));
		if (!crowd && $urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, reply_bytes.size());
			while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
		end
	endtask

	task automatic send_reply();
		int i;
		send_burst = ($urandom_range(0, 3) == 0);
		for (i = 0; i < reply_bytes.size(); i++) begin
			put_byte(reply_bytes[i], i == reply_bytes.size() - 1);
			predict_byte(reply_bytes[i], i == reply_bytes.size() - 1, 1'b1);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("dns_answer_record_parser_unit_test NOT OK");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int      gap;
		result_t got;
		result_t want;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen % 32 == 0) recv_burst = ($urandom_range(0, 2) == 0);
			// long hold-offs back the block up until it stalls the byte channel
			if (results_seen == 20 || results_seen == 100)
				gap = HOLD_CYCLES;
			else
				gap = recv_burst ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			results_seen++;
			got.is_done     = res_ch.is_done;
			got.record_kind = res_ch.record_kind;
			got.addr_high   = res_ch.addr_high;
			got.addr_low    = res_ch.addr_low;
			got.v4_count    = res_ch.v4_count;
			got.v6_count    = res_ch.v6_count;
			got.status      = res_ch.status;
			got.last_of_run = res_ch.last_of_run;
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				compare_field("is_done", got.is_done, want.is_done);
				compare_field("record_kind", got.record_kind, want.record_kind);
				compare_field("addr_high", got.addr_high, want.addr_high);
				compare_field("addr_low", got.addr_low, want.addr_low);
				compare_field("v4_count", got.v4_count, want.v4_count);
				compare_field("v6_count", got.v6_count, want.v6_count);
				compare_field("status", got.status, want.status);
				compare_field("last_of_run", got.last_of_run, want.last_of_run);
			end
		end
	end

	initial begin : byte_source
		int          i;
		int          ph;
		int          phase_sent;
		logic [15:0] id;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		msg_ch.valid     = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.is_last   = 1'b0;
		mismatches       = 0;
		results_seen     = 0;
		stall_cycles     = 0;
		send_burst       = 1'b0;
		recv_burst       = 1'b0;
		reply_id_reg     = EXPECTED_ID_RST;
		clear_message();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 25; i++) begin
			put_byte(directed_rows[i].data_byte, directed_rows[i].is_last);
			predict_byte(directed_rows[i].data_byte, directed_rows[i].is_last,
				!directed_rows[i].typed);
			if (directed_rows[i].typed) pending_results.push_back(directed_rows[i].want);
		end

		for (ph = 0; ph < 4; ph++) begin
			drain(8);
			case (ph)
			0: id = 16'h0000;
			1: id = 16'hffff;
			default: id = 16'($urandom_range(0, 65535));
			endcase
			write_id(id);
			if (ph == 0) begin
				// runs past the message length bound, the tail only ends the message
				build_reply(2, 1'b0);
				while (reply_bytes.size() < MAX_MESSAGE_DEF + $urandom_range(1, 6))
					push_random(1);
				send_reply();
			end
			if (ph == 1) begin
				build_reply(2 * (MAX_RECORDS_DEF + 2), 1'b1);
				send_reply();
			end
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				build_reply($urandom_range(0, 4), 1'b0);
				phase_sent += reply_bytes.size();
				send_reply();
			end
		end

		drain(20);
		if (mismatches == 0)
			$display("dns_answer_record_parser_unit_test OK");
		else
			$display("dns_answer_record_parser_unit_test NOT OK");
		$finish;
	end

endmodule

>>> files.f
hdl/dnsarp_pkg.sv
hdl/dnsarp_ifs.sv
hdl/dnsarp_parse.sv
hdl/dnsarp_fifo.sv
hdl/dns_answer_record_parser_unit.sv
bench/dns_answer_record_parser_unit_test.sv
